/* rtl/crf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package crf_pkg;

    localparam int PIX_W      = 32;
    localparam int BPP_W      = 3;
    localparam int POS_W      = 13;
    localparam int DIM_W      = 14;
    localparam int OUT_W      = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;

    // pixel size codes
    localparam logic [BPP_W-1:0] BPP_16 = 3'd2;
    localparam logic [BPP_W-1:0] BPP_24 = 3'd3;
    localparam logic [BPP_W-1:0] BPP_32 = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_BPP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DST_BPP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_X    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_Y    = 3'd7;

    typedef struct packed {
        logic [POS_W-1:0] rect_left;
        logic [POS_W-1:0] rect_top;
        logic [DIM_W-1:0] rect_width;
        logic [DIM_W-1:0] rect_height;
        logic [POS_W-1:0] src_origin_x;
        logic [POS_W-1:0] src_origin_y;
    } crf_geom_t;

    // compare stage to bounding box stage
    typedef struct packed {
        logic valid;
        logic differs;
    } crf_cmp_t;

endpackage

`default_nettype wire

/* rtl/crf_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none

interface crf_pix_if;
    import crf_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] src_pixel;
    logic [PIX_W-1:0] dst_pixel;

    modport source (output valid, output src_pixel, output dst_pixel, input ready);
    modport sink   (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

interface crf_res_if;
    import crf_pkg::*;
    logic             valid;
    logic             ready;
    logic             changed;
    logic [OUT_W-1:0] new_left;
    logic [OUT_W-1:0] new_top;
    logic [OUT_W-1:0] new_right;
    logic [OUT_W-1:0] new_bottom;
    logic [OUT_W-1:0] new_src_x;
    logic [OUT_W-1:0] new_src_y;

    modport source (output valid, output changed, output new_left, output new_top,
                    output new_right, output new_bottom, output new_src_x,
                    output new_src_y, input ready);
    modport sink   (input valid, input changed, input new_left, input new_top,
                    input new_right, input new_bottom, input new_src_x,
                    input new_src_y, output ready);
endinterface

interface crf_cfg_if;
    import crf_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/changed_rect_finder_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Port  Role     Word
// pix   sink     src_pixel[31:0], dst_pixel[31:0]: one pixel pair, raster order
// res   source   changed, new_left/top/right/bottom, new_src_x/y (14 bits each)
// cfg   sink     index[2:0], data[13:0]: register write, always ready
//
// One pixel pair per cycle sustained; after the last pair of the rectangle is
// accepted, a result leaves through the compare register, then the box register.
// rst_n clears the scan counters, the bounding box and both valid flags;
// registers return to 4/4 bytes, a 1x1 rectangle at the origin.
// A waiting result stalls input only when the next pair would end a rectangle.
// Any register write restarts the scan.

module changed_rect_finder_top
    import crf_pkg::*;
#(
    parameter int MAX_DIM = 8192
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    crf_pix_if.sink   pix,
    crf_res_if.source res,
    crf_cfg_if.sink   cfg
);

    logic [BPP_W-1:0] src_bpp_reg;
    logic [BPP_W-1:0] dst_bpp_reg;
    crf_geom_t        geom_reg;
    logic             cfg_we;
    crf_cmp_t         cmp;
    logic             take;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_bpp_reg           <= BPP_32;
            dst_bpp_reg           <= BPP_32;
            geom_reg.rect_left    <= '0;
            geom_reg.rect_top     <= '0;
            geom_reg.rect_width   <= DIM_W'(1);
            geom_reg.rect_height  <= DIM_W'(1);
            geom_reg.src_origin_x <= '0;
            geom_reg.src_origin_y <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg.index)
                REG_SRC_BPP: src_bpp_reg           <= cfg.data[BPP_W-1:0];
                REG_DST_BPP: dst_bpp_reg           <= cfg.data[BPP_W-1:0];
                REG_LEFT:    geom_reg.rect_left    <= cfg.data[POS_W-1:0];
                REG_TOP:     geom_reg.rect_top     <= cfg.data[POS_W-1:0];
                REG_WIDTH:   geom_reg.rect_width   <= cfg.data[DIM_W-1:0];
                REG_HEIGHT:  geom_reg.rect_height  <= cfg.data[DIM_W-1:0];
                REG_SRC_X:   geom_reg.src_origin_x <= cfg.data[POS_W-1:0];
                REG_SRC_Y:   geom_reg.src_origin_y <= cfg.data[POS_W-1:0];
                default:     ;
            endcase
        end
    end

    crf_pixel_cmp u_cmp (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (pix),
        .src_bpp (src_bpp_reg),
        .dst_bpp (dst_bpp_reg),
        .cmp     (cmp),
        .take    (take)
    );

    crf_bbox #(
        .MAX_DIM (MAX_DIM)
    ) u_bbox (
        .clk     (clk),
        .rst_n   (rst_n),
        .geom    (geom_reg),
        .restart (cfg_we),
        .cmp     (cmp),
        .take    (take),
        .res     (res)
    );

endmodule

`default_nettype wire

/* rtl/crf_pixel_cmp.sv */
`timescale 1ns / 1ps
`default_nettype none

module crf_pixel_cmp
    import crf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    crf_pix_if.sink               pix,
    input  wire logic [BPP_W-1:0] src_bpp,
    input  wire logic [BPP_W-1:0] dst_bpp,
    output crf_cmp_t              cmp,
    input  wire logic             take
);

    logic             valid_reg;
    logic             differs_reg;
    logic [BPP_W-1:0] sb;
    logic [BPP_W-1:0] db;
    logic             equal;

    function automatic logic [BPP_W-1:0] clamp_bpp(input logic [BPP_W-1:0] b);
        logic [BPP_W-1:0] r;
        r = b;
        if (b < BPP_16)
        begin
            r = BPP_16;
        end
        else if (b > BPP_32)
        begin
            r = BPP_32;
        end
        return r;
    endfunction

    function automatic logic [15:0] rgb565(input logic [PIX_W-1:0] p);
        return {p[23:19], p[15:10], p[7:3]};
    endfunction

    always_comb
    begin
        sb = clamp_bpp(src_bpp);
        db = clamp_bpp(dst_bpp);
        if (sb == db)
        begin
            case (sb)
                BPP_16:  equal = (pix.src_pixel[15:0] == pix.dst_pixel[15:0]);
                BPP_24:  equal = (pix.src_pixel[23:0] == pix.dst_pixel[23:0]);
                default: equal = (pix.src_pixel == pix.dst_pixel);
            endcase
        end
        else if (sb > db)
        begin
            if (db == BPP_24)
            begin
                equal = (pix.src_pixel[23:0] == pix.dst_pixel[23:0]);
            end
            else
            begin
                equal = (rgb565(pix.src_pixel) == pix.dst_pixel[15:0]);
            end
        end
        else
        begin
            if (sb == BPP_24)
            begin
                equal = (pix.dst_pixel[23:0] == pix.src_pixel[23:0]);
            end
            else
            begin
                equal = (rgb565(pix.dst_pixel) == pix.src_pixel[15:0]);
            end
        end
    end

    assign pix.ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pix.valid && pix.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix.valid && pix.ready)
        begin
            differs_reg <= !equal;
        end
    end

    assign cmp = {valid_reg, differs_reg};

endmodule

`default_nettype wire

/* rtl/crf_bbox.sv */
`timescale 1ns / 1ps
`default_nettype none

module crf_bbox
    import crf_pkg::*;
#(
    parameter int MAX_DIM = 8192
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire crf_geom_t geom,
    input  wire logic      restart,
    input  wire crf_cmp_t  cmp,
    output logic           take,
    crf_res_if.source      res
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int EW = (CW + 1 > DIM_W) ? CW + 1 : DIM_W;
    localparam int SW = ((CW > OUT_W) ? CW : OUT_W) + 1;

    logic [CW-1:0]    col_reg, row_reg;
    logic [CW-1:0]    min_col_reg, max_col_reg, min_row_reg, max_row_reg;
    logic             any_reg;
    logic [CW-1:0]    min_col_next, max_col_next, min_row_next, max_row_next;
    logic             any_next;
    logic [CW-1:0]    wm1, hm1;
    logic             row_end, last;
    logic [SW-1:0]    sum_left, sum_top, sum_right, sum_bottom, sum_sx, sum_sy;

    logic             res_valid_reg;
    logic             changed_reg;
    logic [OUT_W-1:0] left_reg, top_reg, right_reg, bottom_reg, sx_reg, sy_reg;
    logic             changed_next;
    logic [OUT_W-1:0] left_next, top_next, right_next, bottom_next, sx_next, sy_next;

    // last index along one dimension, size clamped to 1..MAX_DIM
    function automatic logic [CW-1:0] dim_last(input logic [DIM_W-1:0] d);
        logic [EW-1:0] e;
        logic [CW-1:0] r;
        e = EW'(d);
        if (e == '0)
        begin
            r = '0;
        end
        else if (e > EW'(MAX_DIM))
        begin
            r = CW'(MAX_DIM - 1);
        end
        else
        begin
            r = CW'(e - EW'(1));
        end
        return r;
    endfunction

    always_comb
    begin
        wm1     = dim_last(geom.rect_width);
        hm1     = dim_last(geom.rect_height);
        row_end = (col_reg >= wm1);
        last    = row_end && (row_reg >= hm1);
        take    = cmp.valid && (!last || !res_valid_reg || res.ready);

        min_col_next = min_col_reg;
        max_col_next = max_col_reg;
        min_row_next = min_row_reg;
        max_row_next = max_row_reg;
        any_next     = any_reg;
        if (cmp.differs)
        begin
            if (!any_reg || col_reg < min_col_reg) min_col_next = col_reg;
            if (!any_reg || col_reg > max_col_reg) max_col_next = col_reg;
            if (!any_reg || row_reg < min_row_reg) min_row_next = row_reg;
            if (!any_reg || row_reg > max_row_reg) max_row_next = row_reg;
            any_next = 1'b1;
        end

        sum_left   = SW'(geom.rect_left) + SW'(min_col_next);
        sum_top    = SW'(geom.rect_top) + SW'(min_row_next);
        sum_right  = SW'(geom.rect_left) + SW'(max_col_next) + SW'(1);
        sum_bottom = SW'(geom.rect_top) + SW'(max_row_next) + SW'(1);
        sum_sx     = SW'(geom.src_origin_x) + SW'(min_col_next);
        sum_sy     = SW'(geom.src_origin_y) + SW'(min_row_next);

        changed_next = any_next;
        if (any_next)
        begin
            left_next   = sum_left[OUT_W-1:0];
            top_next    = sum_top[OUT_W-1:0];
            right_next  = sum_right[OUT_W-1:0];
            bottom_next = sum_bottom[OUT_W-1:0];
            sx_next     = sum_sx[OUT_W-1:0];
            sy_next     = sum_sy[OUT_W-1:0];
        end
        else
        begin
            // empty rectangle at the top-left corner
            left_next   = OUT_W'(geom.rect_left);
            top_next    = OUT_W'(geom.rect_top);
            right_next  = OUT_W'(geom.rect_left);
            bottom_next = OUT_W'(geom.rect_top);
            sx_next     = OUT_W'(geom.src_origin_x);
            sy_next     = OUT_W'(geom.src_origin_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            min_col_reg <= '1;
            max_col_reg <= '0;
            min_row_reg <= '1;
            max_row_reg <= '0;
            any_reg     <= 1'b0;
        end
        else if (restart || (take && last))
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            min_col_reg <= '1;
            max_col_reg <= '0;
            min_row_reg <= '1;
            max_row_reg <= '0;
            any_reg     <= 1'b0;
        end
        else if (take)
        begin
            if (row_end)
            begin
                col_reg <= '0;
                row_reg <= row_reg + CW'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
            min_col_reg <= min_col_next;
            max_col_reg <= max_col_next;
            min_row_reg <= min_row_next;
            max_row_reg <= max_row_next;
            any_reg     <= any_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (take && last)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && last)
        begin
            changed_reg <= changed_next;
            left_reg    <= left_next;
            top_reg     <= top_next;
            right_reg   <= right_next;
            bottom_reg  <= bottom_next;
            sx_reg      <= sx_next;
            sy_reg      <= sy_next;
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.changed    = changed_reg;
    assign res.new_left   = left_reg;
    assign res.new_top    = top_reg;
    assign res.new_right  = right_reg;
    assign res.new_bottom = bottom_reg;
    assign res.new_src_x  = sx_reg;
    assign res.new_src_y  = sy_reg;

`ifndef SYNTHESIS
    a_scan_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (take && last) |=> (col_reg == '0 && row_reg == '0 && !any_reg))
        else $error("scan state not cleared after result");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= wm1)
        else $error("column counter past row end");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= hm1)
        else $error("row counter past last row");

    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        any_reg |-> (min_col_reg <= max_col_reg && min_row_reg <= max_row_reg))
        else $error("bounding box inverted");
`endif

endmodule

`default_nettype wire
